// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL; each expands to one labeled concurrent assertion
// clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define NRP_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NRP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nrp_pkg.sv =====
package nrp_pkg;

    localparam int NRP_LINE_MAX    = 128;
    localparam int NRP_FRAC_DIGITS = 5;

    // Characters past this position in a line are counted but not parsed
    localparam int unsigned NRP_PARSE_LIMIT = 127;

    // Field positions within a sentence
    localparam logic [3:0] NRP_FLD_FIX = 4'd2;
    localparam logic [3:0] NRP_FLD_LAT = 4'd3;
    localparam logic [3:0] NRP_FLD_NS  = 4'd4;
    localparam logic [3:0] NRP_FLD_LON = 4'd5;
    localparam logic [3:0] NRP_FLD_EW  = 4'd6;
    localparam logic [3:0] NRP_FLD_SAT = 4'd11;
    localparam logic [3:0] NRP_MIN_COMMAS = 4'd6;

    // ASCII codes
    localparam logic [7:0] NRP_CH_NUL   = 8'h00;
    localparam logic [7:0] NRP_CH_LF    = 8'h0A;
    localparam logic [7:0] NRP_CH_CR    = 8'h0D;
    localparam logic [7:0] NRP_CH_COMMA = 8'h2C;
    localparam logic [7:0] NRP_CH_POINT = 8'h2E;
    localparam logic [7:0] NRP_CH_ZERO  = 8'h30;
    localparam logic [7:0] NRP_CH_NINE  = 8'h39;
    localparam logic [7:0] NRP_CH_A     = 8'h41;
    localparam logic [7:0] NRP_CH_S     = 8'h53;
    localparam logic [7:0] NRP_CH_W     = 8'h57;

    localparam logic [31:0] NRP_SAT32   = 32'hFFFF_FFFF;
    localparam logic [31:0] NRP_MAG_MAX = 32'h7FFF_FFFF;
    localparam logic [23:0] NRP_UNITS   = 24'd10000000;

    // Reciprocal of 60 scaled by 2^32
    localparam logic [26:0] NRP_M60 = 27'((64'd1 << 32) / 64'd60);

    // Width of a power-of-ten factor up to 10^6
    localparam int NRP_FACT_W = 20;

    // Conversion pipeline depth, output register included
    localparam int NRP_STAGES = 9;

    localparam int NRP_Q_DEPTH = 2;

    typedef enum logic [2:0] {
        NRP_ST_OK       = 3'd0,
        NRP_ST_TOO_FEW  = 3'd1,
        NRP_ST_NO_FIX   = 3'd2,
        NRP_ST_EMPTY    = 3'd3,
        NRP_ST_ZERO     = 3'd4
    } nrp_status_t;

    // One closed line as handed from the parser to the converter
    typedef struct packed {
        nrp_status_t status;
        logic [31:0] lat_acc;
        logic [2:0]  lat_frac;
        logic [31:0] lon_acc;
        logic [2:0]  lon_frac;
        logic        south;
        logic        west;
    } nrp_rec_t;

    typedef struct packed {
        logic neg;
        logic kill;
    } nrp_tag_t;

    function automatic longint unsigned pow10(input int n);
        longint unsigned r;
        case (n)
            0:       r = 64'd1;
            1:       r = 64'd10;
            2:       r = 64'd100;
            3:       r = 64'd1000;
            4:       r = 64'd10000;
            5:       r = 64'd100000;
            6:       r = 64'd1000000;
            7:       r = 64'd10000000;
            default: r = 64'd1;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/nrp_front.sv =====
module nrp_front #(
    parameter int LINE_MAX    = nrp_pkg::NRP_LINE_MAX,
    parameter int FRAC_DIGITS = nrp_pkg::NRP_FRAC_DIGITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    output logic              push_valid,
    input  logic              push_ready,
    output nrp_pkg::nrp_rec_t push_rec
);

    localparam int LEN_W = $clog2(LINE_MAX);

    logic [LEN_W-1:0] len_reg;
    logic [3:0]       fld_reg;
    logic [7:0]       fix_reg;
    logic [31:0]      lat_reg;
    logic [31:0]      lon_reg;
    logic [2:0]       frac_reg;
    logic             point_reg;
    logic             ended_reg;
    logic             latp_reg;
    logic             lonp_reg;
    logic             south_reg;
    logic             west_reg;
    logic [2:0]       lat_frac_reg;
    logic [2:0]       lon_frac_reg;

    logic [LEN_W-1:0] len_next;
    logic [3:0]       fld_next;
    logic [7:0]       fix_next;
    logic [31:0]      lat_next;
    logic [31:0]      lon_next;
    logic [2:0]       frac_next;
    logic             point_next;
    logic             ended_next;
    logic             latp_next;
    logic             lonp_next;
    logic             south_next;
    logic             west_next;
    logic [2:0]       lat_frac_next;
    logic [2:0]       lon_frac_next;

    logic        accept;
    logic        is_eol;
    logic        parse_ok;
    logic        is_digit;
    logic [7:0]  dval8;
    logic [31:0] acc_sel;
    logic [35:0] acc_x10;
    logic [31:0] acc_push;
    logic        close;

    assign accept   = in_valid && in_ready;
    assign in_ready = push_ready;

    always_comb
    begin
        is_eol   = (rx_byte == nrp_pkg::NRP_CH_CR) || (rx_byte == nrp_pkg::NRP_CH_LF);
        parse_ok = !is_eol && (32'(len_reg) < nrp_pkg::NRP_PARSE_LIMIT)
                   && (rx_byte != nrp_pkg::NRP_CH_NUL);
        is_digit = (rx_byte >= nrp_pkg::NRP_CH_ZERO) && (rx_byte <= nrp_pkg::NRP_CH_NINE);
        dval8    = rx_byte - nrp_pkg::NRP_CH_ZERO;
        acc_sel  = (fld_reg == nrp_pkg::NRP_FLD_LON) ? lon_reg : lat_reg;
        acc_x10  = (36'(acc_sel) << 3) + (36'(acc_sel) << 1) + 36'(dval8[3:0]);
        acc_push = (acc_x10 > 36'(nrp_pkg::NRP_SAT32)) ? nrp_pkg::NRP_SAT32 : acc_x10[31:0];

        fld_next      = fld_reg;
        fix_next      = fix_reg;
        lat_next      = lat_reg;
        lon_next      = lon_reg;
        frac_next     = frac_reg;
        point_next    = point_reg;
        ended_next    = ended_reg;
        latp_next     = latp_reg;
        lonp_next     = lonp_reg;
        south_next    = south_reg;
        west_next     = west_reg;
        lat_frac_next = lat_frac_reg;
        lon_frac_next = lon_frac_reg;

        if (parse_ok)
        begin
            if (rx_byte == nrp_pkg::NRP_CH_COMMA)
            begin
                if (fld_reg != nrp_pkg::NRP_FLD_SAT)
                begin
                    fld_next = fld_reg + 4'd1;
                end
                frac_next  = 3'd0;
                point_next = 1'b0;
                ended_next = 1'b0;
            end
            else
            begin
                case (fld_reg)
                    nrp_pkg::NRP_FLD_FIX:
                    begin
                        if (fix_reg == nrp_pkg::NRP_CH_NUL)
                        begin
                            fix_next = rx_byte;
                        end
                    end
                    nrp_pkg::NRP_FLD_LAT,
                    nrp_pkg::NRP_FLD_LON:
                    begin
                        if (fld_reg == nrp_pkg::NRP_FLD_LAT)
                        begin
                            latp_next = 1'b1;
                        end
                        else
                        begin
                            lonp_next = 1'b1;
                        end
                        if (!ended_reg)
                        begin
                            if (is_digit)
                            begin
                                // Drop fraction digits beyond the kept precision
                                if (!point_reg || (frac_reg < 3'(FRAC_DIGITS)))
                                begin
                                    if (fld_reg == nrp_pkg::NRP_FLD_LAT)
                                    begin
                                        lat_next = acc_push;
                                    end
                                    else
                                    begin
                                        lon_next = acc_push;
                                    end
                                    if (point_reg)
                                    begin
                                        frac_next = frac_reg + 3'd1;
                                        if (fld_reg == nrp_pkg::NRP_FLD_LAT)
                                        begin
                                            lat_frac_next = frac_reg + 3'd1;
                                        end
                                        else
                                        begin
                                            lon_frac_next = frac_reg + 3'd1;
                                        end
                                    end
                                end
                            end
                            else if ((rx_byte == nrp_pkg::NRP_CH_POINT) && !point_reg)
                            begin
                                point_next = 1'b1;
                            end
                            else
                            begin
                                ended_next = 1'b1;
                            end
                        end
                    end
                    nrp_pkg::NRP_FLD_NS:
                    begin
                        if (!ended_reg)
                        begin
                            south_next = (rx_byte == nrp_pkg::NRP_CH_S);
                        end
                        ended_next = 1'b1;
                    end
                    nrp_pkg::NRP_FLD_EW:
                    begin
                        if (!ended_reg)
                        begin
                            west_next = (rx_byte == nrp_pkg::NRP_CH_W);
                        end
                        ended_next = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        len_next = is_eol ? len_reg : len_reg + LEN_W'(1);
        close    = is_eol ? (len_reg != '0) : (len_reg == LEN_W'(LINE_MAX - 2));

        if (fld_next < nrp_pkg::NRP_MIN_COMMAS)
        begin
            push_rec.status = nrp_pkg::NRP_ST_TOO_FEW;
        end
        else if (fix_next != nrp_pkg::NRP_CH_A)
        begin
            push_rec.status = nrp_pkg::NRP_ST_NO_FIX;
        end
        else if (!latp_next || !lonp_next)
        begin
            push_rec.status = nrp_pkg::NRP_ST_EMPTY;
        end
        else if ((lat_next == '0) || (lon_next == '0))
        begin
            push_rec.status = nrp_pkg::NRP_ST_ZERO;
        end
        else
        begin
            push_rec.status = nrp_pkg::NRP_ST_OK;
        end
        push_rec.lat_acc  = lat_next;
        push_rec.lat_frac = lat_frac_next;
        push_rec.lon_acc  = lon_next;
        push_rec.lon_frac = lon_frac_next;
        push_rec.south    = south_next;
        push_rec.west     = west_next;

        push_valid = accept && close;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            fld_reg      <= '0;
            fix_reg      <= '0;
            lat_reg      <= '0;
            lon_reg      <= '0;
            frac_reg     <= '0;
            point_reg    <= 1'b0;
            ended_reg    <= 1'b0;
            latp_reg     <= 1'b0;
            lonp_reg     <= 1'b0;
            south_reg    <= 1'b0;
            west_reg     <= 1'b0;
            lat_frac_reg <= '0;
            lon_frac_reg <= '0;
        end
        else if (accept)
        begin
            if (close)
            begin
                len_reg      <= '0;
                fld_reg      <= '0;
                fix_reg      <= '0;
                lat_reg      <= '0;
                lon_reg      <= '0;
                frac_reg     <= '0;
                point_reg    <= 1'b0;
                ended_reg    <= 1'b0;
                latp_reg     <= 1'b0;
                lonp_reg     <= 1'b0;
                south_reg    <= 1'b0;
                west_reg     <= 1'b0;
                lat_frac_reg <= '0;
                lon_frac_reg <= '0;
            end
            else if (!is_eol)
            begin
                len_reg      <= len_next;
                fld_reg      <= fld_next;
                fix_reg      <= fix_next;
                lat_reg      <= lat_next;
                lon_reg      <= lon_next;
                frac_reg     <= frac_next;
                point_reg    <= point_next;
                ended_reg    <= ended_next;
                latp_reg     <= latp_next;
                lonp_reg     <= lonp_next;
                south_reg    <= south_next;
                west_reg     <= west_next;
                lat_frac_reg <= lat_frac_next;
                lon_frac_reg <= lon_frac_next;
            end
        end
    end

endmodule

// ===== rtl/nrp_queue.sv =====
module nrp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  nrp_pkg::nrp_rec_t wr_rec,
    output logic              rd_valid,
    input  logic              rd_ready,
    output nrp_pkg::nrp_rec_t rd_rec,
    output logic [$clog2(nrp_pkg::NRP_Q_DEPTH+1)-1:0] count
);

    localparam int DEPTH = nrp_pkg::NRP_Q_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nrp_pkg::nrp_rec_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               do_wr;
    logic               do_rd;

    assign wr_ready = (cnt_reg != CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_rec   = mem_reg[rd_ptr_reg];
    assign count    = cnt_reg;
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/nrp_conv.sv =====
module nrp_conv #(
    parameter int FRAC_DIGITS = nrp_pkg::NRP_FRAC_DIGITS
) (
    input  logic                           clk,
    input  logic [nrp_pkg::NRP_STAGES-1:0] en,
    input  logic [31:0]                    acc,
    input  logic [2:0]                     frac,
    input  nrp_pkg::nrp_tag_t              tag,
    output logic signed [31:0]             value
);

    localparam longint unsigned SCALE   = nrp_pkg::pow10(FRAC_DIGITS);
    localparam longint unsigned UNIT    = 64'd100 * SCALE;
    localparam longint unsigned M_DEG   = (64'd1 << 32) / UNIT;
    localparam longint unsigned DEG_MAX = 64'hFFFF_FFFF / UNIT;
    localparam int DEG_W = $clog2(DEG_MAX + 1);
    localparam int MIN_W = $clog2(UNIT);
    localparam int SUM_W = DEG_W + 25;
    localparam int FW    = nrp_pkg::NRP_FACT_W;

    localparam logic [31:0] M_DEG_C = 32'(M_DEG);
    localparam logic [31:0] UNIT_C  = 32'(UNIT);
    localparam logic [FW-1:0] P7_C  = FW'(nrp_pkg::pow10(7 - FRAC_DIGITS));

    nrp_pkg::nrp_tag_t tag_reg [nrp_pkg::NRP_STAGES-1];

    // Stage 0: scale up to the full fraction width
    logic [2:0]       diff;
    logic [FW-1:0]    factor;
    logic [FW+31:0]   prod0;
    logic [31:0]      scaled_reg;
    // Stage 1: reciprocal product for the degree split
    logic [63:0]      prod1_reg;
    logic [31:0]      sc1_reg;
    // Stage 2: degree estimate and its back product
    logic [DEG_W-1:0] qe_next;
    logic [DEG_W+31:0] mul2;
    logic [DEG_W-1:0] qe_reg;
    logic [31:0]      qd_reg;
    logic [31:0]      sc2_reg;
    // Stage 3: correct degrees, remainder is minutes
    logic [31:0]      r3;
    logic             ge3;
    logic [31:0]      min_full;
    logic [DEG_W-1:0] deg_reg;
    logic [MIN_W-1:0] min_reg;
    // Stage 4: minutes to 1e-7 units times 60, degrees to 1e-7 units
    logic [MIN_W+FW-1:0] mul4;
    logic [29:0]      m2_reg;
    logic [DEG_W+23:0] degu_reg;
    // Stage 5: reciprocal product for divide by 60
    logic [56:0]      p60_reg;
    logic [29:0]      m2b_reg;
    logic [DEG_W+23:0] degu2_reg;
    // Stage 6: quotient estimate and remainder
    logic [23:0]      q60_next;
    logic [29:0]      t6;
    logic [29:0]      r6;
    logic [23:0]      q60_reg;
    logic [6:0]       r60_reg;
    logic [DEG_W+23:0] degu3_reg;
    // Stage 7: sum
    logic [SUM_W-1:0] sum_reg;
    // Stage 8: saturate and sign
    logic [31:0]      mag;
    logic [31:0]      val_next;
    logic [31:0]      value_reg;

    always_comb
    begin
        diff     = 3'(FRAC_DIGITS) - frac;
        factor   = FW'(nrp_pkg::pow10(int'(diff)));
        prod0    = acc * factor;
        qe_next  = prod1_reg[32 +: DEG_W];
        mul2     = qe_next * UNIT_C;
        r3       = sc2_reg - qd_reg;
        ge3      = (r3 >= UNIT_C);
        min_full = ge3 ? (r3 - UNIT_C) : r3;
        mul4     = min_reg * P7_C;
        q60_next = p60_reg[55:32];
        t6       = 30'(q60_next) * 30'd60;
        r6       = m2b_reg - t6;
        mag      = ((SUM_W + 8)'(sum_reg) > (SUM_W + 8)'(nrp_pkg::NRP_MAG_MAX))
                   ? nrp_pkg::NRP_MAG_MAX : 32'(sum_reg);
        if (tag_reg[nrp_pkg::NRP_STAGES-2].kill)
        begin
            val_next = '0;
        end
        else if (tag_reg[nrp_pkg::NRP_STAGES-2].neg)
        begin
            val_next = 32'd0 - mag;
        end
        else
        begin
            val_next = mag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            tag_reg[0] <= tag;
            scaled_reg <= (prod0 > (FW+32)'(nrp_pkg::NRP_SAT32)) ? nrp_pkg::NRP_SAT32
                                                                  : prod0[31:0];
        end
        for (int k = 1; k < nrp_pkg::NRP_STAGES - 1; k++)
        begin
            if (en[k])
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
        if (en[1])
        begin
            prod1_reg <= scaled_reg * M_DEG_C;
            sc1_reg   <= scaled_reg;
        end
        if (en[2])
        begin
            qe_reg  <= qe_next;
            qd_reg  <= mul2[31:0];
            sc2_reg <= sc1_reg;
        end
        if (en[3])
        begin
            deg_reg <= qe_reg + DEG_W'(ge3);
            min_reg <= min_full[MIN_W-1:0];
        end
        if (en[4])
        begin
            m2_reg   <= mul4[29:0];
            degu_reg <= deg_reg * nrp_pkg::NRP_UNITS;
        end
        if (en[5])
        begin
            p60_reg   <= m2_reg * nrp_pkg::NRP_M60;
            m2b_reg   <= m2_reg;
            degu2_reg <= degu_reg;
        end
        if (en[6])
        begin
            q60_reg   <= q60_next;
            r60_reg   <= r6[6:0];
            degu3_reg <= degu2_reg;
        end
        if (en[7])
        begin
            sum_reg <= SUM_W'(degu3_reg) + SUM_W'(q60_reg) + SUM_W'(r60_reg >= 7'd60);
        end
        if (en[8])
        begin
            value_reg <= val_next;
        end
    end

    assign value = value_reg;

endmodule

// ===== rtl/nrp_back.sv =====
module nrp_back #(
    parameter int FRAC_DIGITS = nrp_pkg::NRP_FRAC_DIGITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  nrp_pkg::nrp_rec_t in_rec,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic signed [31:0] latitude,
    output logic signed [31:0] longitude
);

    localparam int NS = nrp_pkg::NRP_STAGES;

    logic [NS-1:0]       v_reg;
    logic [NS-1:0]       en;
    nrp_pkg::nrp_status_t st_reg [NS];
    nrp_pkg::nrp_tag_t   lat_tag;
    nrp_pkg::nrp_tag_t   lon_tag;

    // A stage moves when it is empty or the one after it moves
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_comb
    begin
        lat_tag.neg  = in_rec.south;
        lat_tag.kill = (in_rec.status != nrp_pkg::NRP_ST_OK);
        lon_tag.neg  = in_rec.west;
        lon_tag.kill = (in_rec.status != nrp_pkg::NRP_ST_OK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            st_reg[0] <= in_rec.status;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
            begin
                st_reg[k] <= st_reg[k-1];
            end
        end
    end

    nrp_conv #(
        .FRAC_DIGITS(FRAC_DIGITS)
    ) u_lat (
        .clk   (clk),
        .en    (en),
        .acc   (in_rec.lat_acc),
        .frac  (in_rec.lat_frac),
        .tag   (lat_tag),
        .value (latitude)
    );

    nrp_conv #(
        .FRAC_DIGITS(FRAC_DIGITS)
    ) u_lon (
        .clk   (clk),
        .en    (en),
        .acc   (in_rec.lon_acc),
        .frac  (in_rec.lon_frac),
        .tag   (lon_tag),
        .value (longitude)
    );

    assign out_valid = v_reg[NS-1];
    assign status    = st_reg[NS-1];

endmodule

// ===== rtl/nmea_rmc_position_parser_top.sv =====
// RMC position parser.
// Input channel (in_valid/in_ready, rx_byte): one ASCII character per item, one item per
// cycle at most. CR or LF ends a line, empty lines are dropped, and a line also ends on its
// LINE_MAX-1th character. Each line produces one result item.
// Output channel (out_valid/out_ready): status plus signed latitude and longitude in
// 1e-7 degree; both coordinates read zero unless status is ok.
// Result path: the line record goes into a two-entry line queue and then through the
// nine-stage conversion pipeline (two reciprocal divides, each a multiply, a back product
// and a correction) before the result is offered.
// Throughput: one character per cycle while the queue has room; a new result can leave
// every cycle while out_ready is high. A stalled receiver holds the current result; the
// pipeline and then the queue fill, and in_ready drops whenever the queue is full.
// Reset clears the line parser, the queue and all pipeline valids; no result is pending
// after reset.
`include "assert_macros.svh"

module nmea_rmc_position_parser_top #(
    parameter int LINE_MAX    = nrp_pkg::NRP_LINE_MAX,
    parameter int FRAC_DIGITS = nrp_pkg::NRP_FRAC_DIGITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] latitude,
    output logic signed [31:0] longitude
);

    localparam int CNT_W = $clog2(nrp_pkg::NRP_Q_DEPTH + 1);

    logic              q_push;
    logic              q_ready;
    nrp_pkg::nrp_rec_t q_wr_rec;
    logic              q_valid;
    logic              q_pop_ready;
    nrp_pkg::nrp_rec_t q_rd_rec;
    logic [CNT_W-1:0]  q_count;
    logic              q_pop;

    nrp_front #(
        .LINE_MAX    (LINE_MAX),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .push_valid (q_push),
        .push_ready (q_ready),
        .push_rec   (q_wr_rec)
    );

    nrp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_push),
        .wr_ready (q_ready),
        .wr_rec   (q_wr_rec),
        .rd_valid (q_valid),
        .rd_ready (q_pop_ready),
        .rd_rec   (q_rd_rec),
        .count    (q_count)
    );

    nrp_back #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_pop_ready),
        .in_rec    (q_rd_rec),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .latitude  (latitude),
        .longitude (longitude)
    );

    assign q_pop = q_valid && q_pop_ready;

    `NRP_ASSERT_IMPL(a_err_zero_coords, out_valid && (status != nrp_pkg::NRP_ST_OK), (latitude == 32'sd0) && (longitude == 32'sd0), "coordinates not zero on error status")
    `NRP_ASSERT_IMPL(a_queue_no_overflow, q_push, q_ready, "line pushed into a full queue")
    `NRP_ASSERT_NEXT(a_queue_count, q_push && !q_pop, q_count == $past(q_count) + CNT_W'(1), "queue count did not grow on push")

endmodule

// ===== verif/nmea_rmc_position_parser_top_tb.sv =====
`timescale 1ns / 100ps

module nmea_rmc_position_parser_top_tb;

    localparam int LIMIT      = 200000;
    localparam int QUIET_LO   = 1200;
    localparam int QUIET_HI   = 2000;
    localparam int HOLD_A_AT  = 500;
    localparam int HOLD_A_LEN = 900;
    localparam int HOLD_B_AT  = 150;
    localparam int HOLD_B_LEN = 150;
    localparam int TAIL       = 40;
    localparam int N_ITEMS    = 1250;

    localparam logic [7:0] CH_N = "N";
    localparam logic [7:0] CH_E = "E";

    typedef struct packed {
        nrp_pkg::nrp_status_t st;
        logic signed [31:0]   lat;
        logic signed [31:0]   lon;
    } pos_fix_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         status;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;

    logic [7:0] char_q[$];
    logic [7:0] line_buf[$];
    pos_fix_t   fix_q[$];
    int         n_err = 0;
    int         n_lines = 0;
    int         cyc = 0;
    int         hold_left;

    // Parser state of the predictor
    int          line_len;
    logic [3:0]  fld;
    logic [7:0]  fix_ch;
    logic [31:0] lat_raw;
    logic [31:0] lon_raw;
    int          frac_n;
    logic        pt_seen;
    logic        num_done;
    logic        lat_seen;
    logic        lon_seen;
    logic        is_south;
    logic        is_west;

    wire quiet = (cyc >= QUIET_LO) && (cyc < QUIET_HI);

    nmea_rmc_position_parser_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .latitude  (latitude),
        .longitude (longitude)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc == LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] acc_digit(logic [31:0] acc, int d);
        longint unsigned v;
        v = longint'(acc) * 10 + d;
        return (v > 64'hFFFF_FFFF) ? nrp_pkg::NRP_SAT32 : v[31:0];
    endfunction

    function automatic logic [31:0] take_char(logic [31:0] acc, logic [7:0] c);
        if (num_done)
            return acc;
        if (c >= nrp_pkg::NRP_CH_ZERO && c <= nrp_pkg::NRP_CH_NINE)
        begin
            if (!pt_seen)
                return acc_digit(acc, c - nrp_pkg::NRP_CH_ZERO);
            if (frac_n < nrp_pkg::NRP_FRAC_DIGITS)
            begin
                frac_n++;
                return acc_digit(acc, c - nrp_pkg::NRP_CH_ZERO);
            end
        end
        else if (c == nrp_pkg::NRP_CH_POINT && !pt_seen)
            pt_seen = 1'b1;
        else
            num_done = 1'b1;
        return acc;
    endfunction

    // ddmm.mmmmm fixed point to signed 1e-7 degree
    function automatic logic signed [31:0] to_deg7(logic [31:0] raw, logic neg);
        longint unsigned sc;
        longint unsigned whole;
        longint unsigned mins;
        longint unsigned mag;
        logic [31:0]     m;
        sc = 1;
        for (int k = 0; k < nrp_pkg::NRP_FRAC_DIGITS; k++)
            sc = sc * 10;
        whole = longint'(raw) / (100 * sc);
        mins  = longint'(raw) - whole * 100 * sc;
        mag   = whole * nrp_pkg::NRP_UNITS + (mins * nrp_pkg::NRP_UNITS) / (60 * sc);
        if (mag > nrp_pkg::NRP_MAG_MAX)
            mag = nrp_pkg::NRP_MAG_MAX;
        m = mag[31:0];
        return neg ? -m : m;
    endfunction

    task automatic clear_field();
        frac_n   = 0;
        pt_seen  = 1'b0;
        num_done = 1'b0;
    endtask

    task automatic clear_line();
        line_len = 0;
        fld      = '0;
        fix_ch   = '0;
        lat_raw  = '0;
        lon_raw  = '0;
        lat_seen = 1'b0;
        lon_seen = 1'b0;
        is_south = 1'b0;
        is_west  = 1'b0;
        clear_field();
    endtask

    // Pad a short fraction out to the full fixed-point scale
    task automatic pad_frac();
        for (int k = frac_n; k < nrp_pkg::NRP_FRAC_DIGITS; k++)
        begin
            if (fld == nrp_pkg::NRP_FLD_LAT)
                lat_raw = acc_digit(lat_raw, 0);
            else if (fld == nrp_pkg::NRP_FLD_LON)
                lon_raw = acc_digit(lon_raw, 0);
        end
    endtask

    task automatic close_line();
        pos_fix_t f;
        pad_frac();
        if (fld < nrp_pkg::NRP_MIN_COMMAS)
            f.st = nrp_pkg::NRP_ST_TOO_FEW;
        else if (fix_ch != nrp_pkg::NRP_CH_A)
            f.st = nrp_pkg::NRP_ST_NO_FIX;
        else if (!lat_seen || !lon_seen)
            f.st = nrp_pkg::NRP_ST_EMPTY;
        else if (lat_raw == 0 || lon_raw == 0)
            f.st = nrp_pkg::NRP_ST_ZERO;
        else
            f.st = nrp_pkg::NRP_ST_OK;
        f.lat = (f.st == nrp_pkg::NRP_ST_OK) ? to_deg7(lat_raw, is_south) : '0;
        f.lon = (f.st == nrp_pkg::NRP_ST_OK) ? to_deg7(lon_raw, is_west) : '0;
        fix_q.push_back(f);
        clear_line();
    endtask

    task automatic parse_char(logic [7:0] c);
        if (c == nrp_pkg::NRP_CH_NUL)
            return;
        if (c == nrp_pkg::NRP_CH_COMMA)
        begin
            pad_frac();
            if (fld < nrp_pkg::NRP_FLD_SAT)
                fld = fld + 1'b1;
            clear_field();
            return;
        end
        case (fld)
            nrp_pkg::NRP_FLD_FIX:
                if (fix_ch == 0)
                    fix_ch = c;
            nrp_pkg::NRP_FLD_LAT:
            begin
                lat_seen = 1'b1;
                lat_raw  = take_char(lat_raw, c);
            end
            nrp_pkg::NRP_FLD_NS:
            begin
                if (!num_done)
                    is_south = (c == nrp_pkg::NRP_CH_S);
                num_done = 1'b1;
            end
            nrp_pkg::NRP_FLD_LON:
            begin
                lon_seen = 1'b1;
                lon_raw  = take_char(lon_raw, c);
            end
            nrp_pkg::NRP_FLD_EW:
            begin
                if (!num_done)
                    is_west = (c == nrp_pkg::NRP_CH_W);
                num_done = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic track_char(logic [7:0] c);
        if (c == nrp_pkg::NRP_CH_CR || c == nrp_pkg::NRP_CH_LF)
        begin
            if (line_len != 0)
                close_line();
            return;
        end
        if (line_len < nrp_pkg::NRP_PARSE_LIMIT)
            parse_char(c);
        line_len++;
        if (line_len >= nrp_pkg::NRP_LINE_MAX - 1)
            close_line();
    endtask

    // Sender: advance on each accepted item, idle now and then
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= nrp_pkg::NRP_CH_NUL;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                track_char(rx_byte);
            if (char_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 7))
            begin
                in_valid <= 1'b1;
                rx_byte  <= char_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    task automatic check_fix();
        pos_fix_t f;
        if (fix_q.size() == 0)
        begin
            $display("%0t: unexpected item, status %0d lat %0d lon %0d",
                     $time, status, latitude, longitude);
            n_err++;
            return;
        end
        f = fix_q.pop_front();
        if (status !== f.st)
        begin
            $display("%0t: status expected %0d actual %0d", $time, f.st, status);
            n_err++;
        end
        if (latitude !== f.lat)
        begin
            $display("%0t: latitude expected %0d actual %0d", $time, f.lat, latitude);
            n_err++;
        end
        if (longitude !== f.lon)
        begin
            $display("%0t: longitude expected %0d actual %0d", $time, f.lon, longitude);
            n_err++;
        end
    endtask

    // Receiver: check each item, stall at random, hold off twice for a long stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_fix();
            if (cyc == HOLD_A_AT || cyc == HOLD_B_AT)
            begin
                hold_left <= (cyc == HOLD_A_AT) ? HOLD_A_LEN : HOLD_B_LEN;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet || ($urandom_range(0, 99) >= 7);
        end
    end

    task automatic put(logic [7:0] c);
        line_buf.push_back(c);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endtask

    task automatic put_digits(int n);
        repeat (n)
            put(nrp_pkg::NRP_CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(33, 126));
    endfunction

    task automatic put_coord(int deg_digits);
        int    r;
        int    n;
        string junk;
        junk = "- x+";
        r = $urandom_range(0, 99);
        if (r < 5)
            return;
        else if (r < 10)
            put_text("0000.000");
        else if (r < 15)
        begin
            put(junk[$urandom_range(0, 3)]);
            put_digits($urandom_range(1, 4));
        end
        else if (r < 19)
        begin
            // drive the accumulator into saturation
            put_digits($urandom_range(10, 14));
            if ($urandom_range(0, 1))
            begin
                put(nrp_pkg::NRP_CH_POINT);
                put_digits(3);
            end
        end
        else if (r < 23)
        begin
            put_digits(2);
            put(nrp_pkg::NRP_CH_POINT);
            put_digits(2);
            put(nrp_pkg::NRP_CH_POINT);
            put_digits(2);
        end
        else
        begin
            n = deg_digits + 2;
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(0, 6);
            put_digits(n);
            if ($urandom_range(0, 9) != 0)
            begin
                put(nrp_pkg::NRP_CH_POINT);
                put_digits($urandom_range(0, 7));
            end
        end
    endtask

    task automatic put_hemi(logic [7:0] pos, logic [7:0] neg);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            put($urandom_range(0, 1) ? pos : neg);
        else if (r < 80)
            return;
        else if (r < 90)
        begin
            put(neg);
            put(printable());
        end
        else
            put(printable());
    endtask

    task automatic put_sentence();
        int r;
        if ($urandom_range(0, 1))
            put_text("$GPRMC,");
        else
            put_text("$GNRMC,");
        if ($urandom_range(0, 1))
        begin
            put_digits(6);
            put(nrp_pkg::NRP_CH_POINT);
            put_digits(2);
        end
        put(nrp_pkg::NRP_CH_COMMA);
        r = $urandom_range(0, 99);
        if (r < 80)
            put(nrp_pkg::NRP_CH_A);
        else if (r < 88)
            put_text("V");
        else if (r >= 94)
        begin
            put($urandom_range(0, 1) ? nrp_pkg::NRP_CH_A : printable());
            put(printable());
        end
        put(nrp_pkg::NRP_CH_COMMA);
        put_coord(2);
        put(nrp_pkg::NRP_CH_COMMA);
        put_hemi(CH_N, nrp_pkg::NRP_CH_S);
        put(nrp_pkg::NRP_CH_COMMA);
        put_coord(3);
        put(nrp_pkg::NRP_CH_COMMA);
        put_hemi(CH_E, nrp_pkg::NRP_CH_W);
        repeat ($urandom_range(0, 7))
        begin
            put(nrp_pkg::NRP_CH_COMMA);
            put_digits($urandom_range(0, 3));
        end
    endtask

    // Move the line into the send queue, optionally damaged, and end it
    task automatic flush_line(bit mangle);
        int r;
        int pos;
        if (mangle && line_buf.size() > 1)
        begin
            pos = $urandom_range(0, line_buf.size() - 1);
            r = $urandom_range(0, 2);
            if (r == 0)
            begin
                while (line_buf.size() > pos)
                    line_buf.delete(line_buf.size() - 1);
            end
            else if (r == 1)
                line_buf[pos] = 8'($urandom_range(0, 255));
            else
                line_buf.delete(pos);
        end
        foreach (line_buf[i])
            char_q.push_back(line_buf[i]);
        line_buf.delete();
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            char_q.push_back(nrp_pkg::NRP_CH_CR);
            char_q.push_back(nrp_pkg::NRP_CH_LF);
        end
        else if (r < 7)
            char_q.push_back(nrp_pkg::NRP_CH_LF);
        else
            char_q.push_back(nrp_pkg::NRP_CH_CR);
        n_lines++;
    endtask

    initial
    begin
        int r;

        clear_line();

        // empty lines, then each status and the corner cases of the number syntax
        char_q.push_back(nrp_pkg::NRP_CH_LF);
        char_q.push_back(nrp_pkg::NRP_CH_CR);
        put(nrp_pkg::NRP_CH_NUL);
        flush_line(0);
        put_text("R,,A,1,S,2,W");
        flush_line(0);
        put_text("R,,V,1,N,1,E");
        flush_line(0);
        put_text("R,,,1,N,1,E");
        flush_line(0);
        put_text("R,,A,,N,1,E");
        flush_line(0);
        put_text("R,,A,0.0,N,1,E");
        flush_line(0);
        put_text("R,,A,9959.9999999,S,17959.99,W,1,2,3,4,5,6,7");
        flush_line(0);
        put_text("R,,A,99999999999,N,25000.5,Ex");
        flush_line(0);
        put_text("R,,A,-5,N,1 2,W");
        flush_line(0);
        put_text("R,,A,1.2.3,N, 7,E");
        flush_line(0);
        put_text("R,A,1,N");
        flush_line(0);
        repeat (130)
            put(printable());
        flush_line(0);

        while (char_q.size() < N_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                put_sentence();
                flush_line(0);
            end
            else if (r < 87)
            begin
                put_sentence();
                flush_line(1);
            end
            else if (r < 97)
            begin
                repeat ($urandom_range(1, 24))
                    put(8'($urandom_range(0, 255)));
                flush_line(0);
            end
            else
            begin
                repeat ($urandom_range(120, 140))
                    put(printable());
                flush_line(0);
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (char_q.size() != 0 || in_valid || fix_q.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);

        if (n_err == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
